// ===== rtl/core/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// shared types and constants for the tridiagonal solver
// ----------------------------------------------------------------------------
package tss_pkg;
  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = 32;
endpackage

// ===== rtl/core/tridiagonal_system_solver.sv =====
// ----------------------------------------------------------------------------
// tridiagonal_system_solver
// thomas algorithm solver, signed q16.16; forward sweep per row, then back
// substitution streamed from last row to row zero
// a new row is accepted only once the previous row is done: two serial divisions
// per row; a zero pivot skips them
// after the last row, no new row is accepted until every unknown has been
// transferred; each unknown waits for the output handshake
// synchronous active-low reset clears control state; stores are not cleared
// ----------------------------------------------------------------------------
module tridiagonal_system_solver
  import tss_pkg::*;
#(
  parameter int MAX_ROWS    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] in_sub_diag,
  input  logic signed [31:0] in_main_diag,
  input  logic signed [31:0] in_super_diag,
  input  logic signed [31:0] in_rhs,
  input  logic        in_last_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_solution,
  output logic [5:0]  out_row_index,
  output logic        out_last_out,
  output logic        out_status
);
  localparam int W  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  localparam logic [3:0] S_IDLE = 4'd0, S_G = 4'd1, S_DA = 4'd2, S_WA = 4'd3,
    S_B = 4'd4, S_DB = 4'd5, S_WB = 4'd6, S_WR = 4'd7, S_RD = 4'd8,
    S_RW = 4'd9, S_MUL = 4'd10, S_ADD = 4'd11, S_OUT = 4'd12;

  function automatic logic signed [W-1:0] sat(input logic signed [2*W+1:0] v);
    if (v > (2*W+2)'(WMAX)) return WMAX;
    if (v < (2*W+2)'(WMIN)) return WMIN;
    return v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] fin(input logic signed [31:0] v);
    return sat((2*W+2)'(v));
  endfunction

  logic [3:0] st_r;
  logic signed [W-1:0] a_r, b_r, c_r, d_r, pa_r, pb_r, g_r, al_r, x_r, t_r;
  logic signed [2*W+1:0] p_r;
  logic [AW-1:0] idx_r, k_r;
  logic [6:0] cnt_r;
  logic perr_r, last_r;
  logic dstart;
  logic signed [W-1:0] dnum, dquo;
  logic ddone;
  logic we;
  logic [AW-1:0] raddr;
  logic [W-1:0] ard, brd;
  logic signed [2*W+1:0] rnd;
  logic signed [W-1:0] ma, mb;
  logic signed [2*W-1:0] mp;

  assign rnd = (p_r + (2*W+2)'(1 << (FRAC_BITS-1))) >>> FRAC_BITS;

  // one shared multiplier, operands chosen by state
  always_comb begin
    case (st_r)
      S_IDLE: begin
        ma = (cnt_r == '0) ? '0 : fin(in_sub_diag);
        mb = pa_r;
      end
      S_G: begin
        ma = a_r;
        mb = pb_r;
      end
      default: begin
        ma = $signed(ard);
        mb = x_r;
      end
    endcase
  end
  assign mp = ma * mb;

  tss_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(g_r),
    .done(ddone), .quo(dquo)
  );
  tss_ram #(.WIDTH(W), .DEPTH(MAX_ROWS)) u_alpha (
    .clk(clk), .we(we), .waddr(idx_r), .wdata(al_r), .raddr(raddr), .rdata(ard)
  );
  tss_ram #(.WIDTH(W), .DEPTH(MAX_ROWS)) u_beta (
    .clk(clk), .we(we), .waddr(idx_r), .wdata(pb_r), .raddr(raddr), .rdata(brd)
  );

  assign in_ready = (st_r == S_IDLE);
  assign we = (st_r == S_WR);
  assign raddr = k_r;
  assign dstart = (st_r == S_DA || st_r == S_DB);
  assign dnum = (st_r == S_DA) ? sat(-(2*W+2)'(c_r)) : t_r;
  assign out_valid = (st_r == S_OUT);
  assign out_solution = 32'(x_r);
  assign out_row_index = 6'(k_r);
  assign out_last_out = (k_r == '0);
  assign out_status = perr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pa_r <= '0;
      pb_r <= '0;
      cnt_r <= '0;
      perr_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (in_valid) begin
          idx_r <= AW'(cnt_r);
          last_r <= in_last_row || (cnt_r >= 7'(MAX_ROWS - 1));
          a_r <= (cnt_r == '0) ? '0 : fin(in_sub_diag);
          b_r <= fin(in_main_diag);
          c_r <= (in_last_row || (cnt_r >= 7'(MAX_ROWS - 1))) ? '0 : fin(in_super_diag);
          d_r <= fin(in_rhs);
          p_r <= (2*W+2)'(mp);
          st_r <= S_G;
        end
        S_G: begin
          g_r <= sat((2*W+2)'(b_r) + (2*W+2)'(sat(rnd)));
          p_r <= (2*W+2)'(mp);
          st_r <= S_DA;
        end
        S_DA: begin
          t_r <= sat((2*W+2)'(d_r) - (2*W+2)'(sat(rnd)));
          if (g_r == '0) begin
            perr_r <= 1'b1;
            al_r <= '0;
            pb_r <= '0;
            st_r <= S_WR;
          end else st_r <= S_WA;
        end
        S_WA: if (ddone) begin
          al_r <= dquo;
          st_r <= S_DB;
        end
        S_DB: st_r <= S_WB;
        S_WB: if (ddone) begin
          pb_r <= dquo;
          st_r <= S_WR;
        end
        S_WR: begin
          pa_r <= al_r;
          if (last_r) begin
            k_r <= idx_r;
            st_r <= S_RD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
            st_r <= S_IDLE;
          end
        end
        S_RD: st_r <= S_RW;
        S_RW: begin
          if (k_r == idx_r) begin
            x_r <= brd;
            st_r <= S_OUT;
          end else begin
            p_r <= (2*W+2)'(mp);
            t_r <= brd;
            st_r <= S_MUL;
          end
        end
        S_MUL: st_r <= S_ADD;
        S_ADD: begin
          x_r <= sat((2*W+2)'(sat(rnd)) + (2*W+2)'(t_r));
          st_r <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          if (k_r == '0) begin
            pa_r <= '0;
            pb_r <= '0;
            cnt_r <= '0;
            perr_r <= 1'b0;
            st_r <= S_IDLE;
          end else begin
            k_r <= k_r - 1'b1;
            st_r <= S_RD;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_index))
    else $error("result dropped");
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> idx_r <= AW'(MAX_ROWS - 1)) else $error("write beyond store");
endmodule

// ===== rtl/core/tss_ram.sv =====
// ----------------------------------------------------------------------------
// tss_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/tss_div.sv =====
// ----------------------------------------------------------------------------
// tss_div
// iterative signed fixed-point divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tss_div
  import tss_pkg::*;
#(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  output logic                done,
  output logic signed [W-1:0] quo
);
  localparam int NW = W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] n_r, n_nxt;
  logic [W-1:0]  d_r;
  logic [W:0]    rem_r, rem_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic          neg_r, busy_r;
  logic [CW-1:0] cnt_r;
  logic [W:0]    trial;
  logic [NW:0]   sq;
  logic [W-1:0]  an, ad;

  assign an = num[W-1] ? W'(-num) : W'(num);
  assign ad = den[W-1] ? W'(-den) : W'(den);
  assign trial = {rem_r[W-1:0], n_r[NW-1]} - {1'b0, d_r};
  always_comb begin
    n_nxt = {n_r[NW-2:0], 1'b0};
    if (!trial[W]) begin
      rem_nxt = trial;
      q_nxt = {q_r[NW-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[W-1:0], n_r[NW-1]};
      q_nxt = {q_r[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r <= {an, {FRAC_BITS{1'b0}}};
      d_r <= ad;
      rem_r <= '0;
      q_r <= '0;
      neg_r <= num[W-1] ^ den[W-1];
    end else if (busy_r) begin
      n_r <= n_nxt;
      rem_r <= rem_nxt;
      q_r <= q_nxt;
    end
  end

  always_comb begin
    sq = neg_r ? -{1'b0, q_r} : {1'b0, q_r};
    if (!neg_r && q_r > NW'({1'b0, {(W-1){1'b1}}}))
      quo = {1'b0, {(W-1){1'b1}}};
    else if (neg_r && q_r > NW'({1'b1, {(W-1){1'b0}}}))
      quo = {1'b1, {(W-1){1'b0}}};
    else
      quo = sq[W-1:0];
  end
endmodule

// ===== test/tb_tridiagonal_system_solver.sv =====
// ----------------------------------------------------------------------------
// tb_tridiagonal_system_solver
// drives tridiagonal systems row by row with random gaps on both sides,
// predicts every unknown in q16.16 and checks each result transfer in order
// ----------------------------------------------------------------------------
module tb_tridiagonal_system_solver
  import tss_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS_MAX = 64;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] solution;
    logic [5:0]         row_index;
    logic               last_out;
    logic               status;
  } unknown_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready;
  logic signed [31:0] in_sub_diag = 0, in_main_diag = 0, in_super_diag = 0, in_rhs = 0;
  logic in_last_row = 0;
  logic out_valid, out_ready = 0;
  logic signed [31:0] out_solution;
  logic [5:0] out_row_index;
  logic out_last_out, out_status;

  tridiagonal_system_solver dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  unknown_t expected_unknowns[$];
  int errors = 0;
  longint unsigned cycles = 0;
  bit stall_free = 0;

  longint alpha_mem[ROWS_MAX];
  longint beta_mem[ROWS_MAX];
  longint alpha_prev, beta_prev;
  int rows_seen;
  bit pivot_zero;

  function automatic longint sat32(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic longint qmul(longint x, longint y);
    return sat32((x * y + 64'sd32768) >>> FRAC_BITS);
  endfunction

  function automatic longint qdiv(longint num, longint den);
    return sat32((num * 64'sd65536) / den);
  endfunction

  task automatic sweep_row(longint a, longint b, longint c, longint d, bit lastf);
    longint g, al, be, x;
    int idx, n;
    unknown_t u;
    idx = rows_seen;
    lastf = lastf || idx >= ROWS_MAX - 1;
    if (idx == 0) a = 0;
    if (lastf) c = 0;
    g = sat32(b + qmul(a, alpha_prev));
    if (g == 0) begin
      pivot_zero = 1;
      al = 0;
      be = 0;
    end else begin
      al = qdiv(sat32(-c), g);
      be = qdiv(sat32(d - qmul(a, beta_prev)), g);
    end
    alpha_mem[idx] = al;
    beta_mem[idx] = be;
    alpha_prev = al;
    beta_prev = be;
    if (!lastf) begin
      rows_seen = idx + 1;
      return;
    end
    n = idx + 1;
    x = 0;
    for (int i = n - 1; i >= 0; i--) begin
      if (i == n - 1) x = beta_mem[i];
      else x = sat32(qmul(alpha_mem[i], x) + beta_mem[i]);
      u.solution = x[31:0];
      u.row_index = i[5:0];
      u.last_out = (i == 0);
      u.status = pivot_zero;
      expected_unknowns = {expected_unknowns, u};
    end
    alpha_prev = 0;
    beta_prev = 0;
    rows_seen = 0;
    pivot_zero = 0;
  endtask

  task automatic send_row(logic signed [31:0] a, b, c, d, logic lastf);
    int gap;
    gap = stall_free ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_sub_diag <= a;
    in_main_diag <= b;
    in_super_diag <= c;
    in_rhs <= d;
    in_last_row <= lastf;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sweep_row(a, b, c, d, lastf);
    @(negedge clk);
  endtask

  // result side: random stalls and in-order check
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      gap = stall_free ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_unknowns.size() == 0) begin
        $display("%0t: unexpected result transfer row %0d sol %h", $time,
                 out_row_index, out_solution);
        errors++;
      end else begin
        unknown_t e;
        e = expected_unknowns.pop_front();
        if (out_solution !== e.solution) begin
          $display("%0t: solution exp %h got %h", $time, e.solution, out_solution);
          errors++;
        end
        if (out_row_index !== e.row_index) begin
          $display("%0t: row_index exp %0d got %0d", $time, e.row_index, out_row_index);
          errors++;
        end
        if (out_last_out !== e.last_out) begin
          $display("%0t: last_out exp %0d got %0d", $time, e.last_out, out_last_out);
          errors++;
        end
        if (out_status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd4000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
    endcase
  endfunction

  task automatic send_system(int n, bit dominant);
    logic signed [31:0] a, b, c;
    for (int i = 0; i < n; i++) begin
      a = dominant ? $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000 : rand_coef();
      c = dominant ? $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000 : rand_coef();
      b = dominant ? 32'sh0004_0000 + $urandom_range(0, 32'h0004_0000) : rand_coef();
      if (dominant && $urandom_range(0, 1)) b = -b;
      send_row(a, b, c, $urandom(), i == n - 1);
    end
  endtask

  task automatic test_single_rows();
    send_row(32'sh1234, 32'sh0002_0000, 32'sh5555, 32'sh0003_0000, 1);
    send_row(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1);
    send_row(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1);
    send_row(0, 32'sh0000_0001, 0, 32'sh7fffffff, 1);
    send_row(32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff, 1);
  endtask

  task automatic test_zero_pivot();
    send_row(0, 0, 32'sh0001_0000, 32'sh0001_0000, 1);
    send_row(0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, 0);
    send_row(32'sh0001_0000, 32'sh0001_0000, 0, 32'sh0001_0000, 0);
    send_row(32'sh0001_0000, 32'sh0002_0000, 32'sh7fffffff, 32'sh0001_0000, 1);
  endtask

  task automatic test_small_systems();
    send_row(32'sh7fffffff, 32'sh0004_0000, 32'sh0001_0000, 32'sh0001_0000, 0);
    send_row(32'sh0001_0000, 32'sh0004_0000, 32'sh0001_0000, 32'sh0002_0000, 0);
    send_row(32'sh0001_0000, 32'sh0004_0000, 32'sh80000000, 32'sh0003_0000, 1);
    send_row(32'sh7fffffff, 32'sh0000_0100, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_row(32'sh80000000, 32'sh0000_0100, 32'sh80000000, 32'sh80000000, 1);
  endtask

  task automatic test_row_overflow();
    send_system(64, 1);
    for (int i = 0; i < 64; i++)
      send_row($urandom(), 32'sh0003_0000, $urandom(), $urandom(), 0);
  endtask

  task automatic test_random_systems();
    int sent;
    sent = 0;
    while (sent < 180) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
      stall_free = ($urandom_range(0, 5) == 0);
      send_system(n, $urandom_range(0, 3) != 0);
      sent += n;
    end
    stall_free = 0;
  endtask

  initial begin
    alpha_prev = 0;
    beta_prev = 0;
    rows_seen = 0;
    pivot_zero = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1;
    test_single_rows();
    test_zero_pivot();
    test_small_systems();
    test_row_overflow();
    test_random_systems();
    in_valid <= 0;
    while (expected_unknowns.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_unknowns.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
